@@ design/ips_pkg.sv @@
package ips_pkg;

	// Default sizes of the unit
	localparam int unsigned IPS_EXPONENT_BITS = 32;
	localparam int unsigned IPS_WORD_BITS     = 64;

	// Pipeline registers per exponent bit: partial products, then sum
	localparam int unsigned IPS_STAGES_PER_BIT = 2;

endpackage

@@ design/integer_power_by_squaring.sv @@
// Throughput: one item per cycle once busy is low; each exponent bit owns a partial-product
// stage and a summing stage, so the 32x32 multipliers set the cycle.
// The receiver cannot stall: done pulses for one cycle with power valid.
// Reset (arst_n low) clears all valid bits and holds busy high; busy drops
// in the first clock after reset is released and stays low.
module integer_power_by_squaring
	import ips_pkg::*;
#(
	parameter int unsigned EXPONENT_BITS = IPS_EXPONENT_BITS,
	parameter int unsigned WORD_BITS     = IPS_WORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [WORD_BITS-1:0]     base,
	input  logic [EXPONENT_BITS-1:0] exponent,
	output logic                     done,
	output logic [WORD_BITS-1:0]     power
);

	// Operand split for low-half multiplies
	localparam int unsigned LO  = WORD_BITS / 2;
	localparam int unsigned HI  = WORD_BITS - LO;
	localparam int unsigned LAT = IPS_STAGES_PER_BIT * EXPONENT_BITS;

	// Inputs of each squaring step; index EXPONENT_BITS is the pipe output
	logic [WORD_BITS-1:0]     st_sq   [EXPONENT_BITS+1];
	logic [WORD_BITS-1:0]     st_prod [EXPONENT_BITS+1];
	logic [EXPONENT_BITS-1:0] st_exp  [EXPONENT_BITS+1];
	logic                     st_vld  [EXPONENT_BITS+1];

	logic busy_q;

	// Busy only while in reset; the pipe never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// Step zero: square starts at base, product at one
	assign st_sq[0]   = base;
	assign st_prod[0] = WORD_BITS'(1);
	assign st_exp[0]  = exponent;
	assign st_vld[0]  = start & ~busy_q;

	for (genvar g = 0; g < EXPONENT_BITS; g++) begin : g_step
		logic [2*LO-1:0]          sq_ll_s1;
		logic [HI-1:0]            sq_lh_s1;
		logic [HI-1:0]            sq_hl_s1;
		logic [2*LO-1:0]          pr_ll_s1;
		logic [HI-1:0]            pr_lh_s1;
		logic [HI-1:0]            pr_hl_s1;
		logic [WORD_BITS-1:0]     prod_s1;
		logic                     take_s1;
		logic [EXPONENT_BITS-1:0] exp_s1;
		logic                     vld_s1;

		logic [WORD_BITS-1:0]     sq_s2;
		logic [WORD_BITS-1:0]     prod_s2;
		logic [EXPONENT_BITS-1:0] exp_s2;
		logic                     vld_s2;

		logic [WORD_BITS-1:0]     sq_sum;
		logic [WORD_BITS-1:0]     pr_sum;

		logic [LO-1:0] sq_lo;
		logic [HI-1:0] sq_hi;
		logic [LO-1:0] pr_lo;
		logic [HI-1:0] pr_hi;

		assign sq_lo = st_sq[g][LO-1:0];
		assign sq_hi = st_sq[g][WORD_BITS-1:LO];
		assign pr_lo = st_prod[g][LO-1:0];
		assign pr_hi = st_prod[g][WORD_BITS-1:LO];

		// Valid bits of both stages
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
			end else begin
				vld_s1 <= st_vld[g];
				vld_s2 <= vld_s1;
			end
		end

		// Stage 1: partial products of square*square and product*square
		always_ff @(posedge clk) begin
			sq_ll_s1 <= (2*LO)'(sq_lo) * (2*LO)'(sq_lo);
			sq_lh_s1 <= HI'(sq_lo) * sq_hi;
			sq_hl_s1 <= sq_hi * HI'(sq_lo);
			pr_ll_s1 <= (2*LO)'(pr_lo) * (2*LO)'(sq_lo);
			pr_lh_s1 <= HI'(pr_lo) * sq_hi;
			pr_hl_s1 <= pr_hi * HI'(sq_lo);
			prod_s1  <= st_prod[g];
			take_s1  <= st_exp[g][0];
			exp_s1   <= st_exp[g] >> 1;
		end

		// Low word of each product: low partial plus shifted cross terms
		always_comb begin
			sq_sum = WORD_BITS'(sq_ll_s1) + {HI'(sq_lh_s1 + sq_hl_s1), LO'(0)};
			pr_sum = WORD_BITS'(pr_ll_s1) + {HI'(pr_lh_s1 + pr_hl_s1), LO'(0)};
		end

		// Stage 2: new square, product updated where the bit is set
		always_ff @(posedge clk) begin
			sq_s2   <= sq_sum;
			prod_s2 <= take_s1 ? pr_sum : prod_s1;
			exp_s2  <= exp_s1;
		end

		assign st_sq[g+1]   = sq_s2;
		assign st_prod[g+1] = prod_s2;
		assign st_exp[g+1]  = exp_s2;
		assign st_vld[g+1]  = vld_s2;
	end

	assign done  = st_vld[EXPONENT_BITS];
	assign power = st_prod[EXPONENT_BITS];

	// Each done pulse answers an item accepted at the pipe input
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without an accepted item");

	// Each accepted item gets its done pulse
	a_item_answered: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy, LAT) |-> done)
		else $error("accepted item got no done");

	// A zero exponent yields one
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (exponent == '0), LAT)
		|-> power == WORD_BITS'(1))
		else $error("zero exponent did not give one");

	// Zero base with a nonzero exponent yields zero
	a_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (base == '0) && (exponent != '0), LAT)
		|-> power == '0)
		else $error("zero base did not give zero");

	// Once out of reset the unit stays ready
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

endmodule
